@@ hdl/hmp_pkg.sv @@
// Shared types, constants and literal tables for the HTTP message header parser.
`default_nettype none
package hmp_pkg;

  localparam int unsigned PositionBitsDef = 16;
  localparam int unsigned LengthBitsDef   = 64;
  localparam int unsigned QueueDepth      = 4;

  // event codes
  localparam logic [2:0] EV_REQUEST  = 3'd0;
  localparam logic [2:0] EV_RESPONSE = 3'd1;
  localparam logic [2:0] EV_FIELD    = 3'd2;
  localparam logic [2:0] EV_BODY     = 3'd3;
  localparam logic [2:0] EV_CHUNK    = 3'd4;
  localparam logic [2:0] EV_BODY_END = 3'd5;
  localparam logic [2:0] EV_TRAILER  = 3'd6;
  localparam logic [2:0] EV_ERROR    = 3'd7;

  // error kinds
  localparam logic [1:0] ERR_PROTO = 2'd0;
  localparam logic [1:0] ERR_SIZE  = 2'd1;
  localparam logic [1:0] ERR_DONE  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_RESP_MODE = 3'd0;
  localparam logic [2:0] REG_METH_LIM  = 3'd1;
  localparam logic [2:0] REG_URI_LIM   = 3'd2;
  localparam logic [2:0] REG_NAME_LIM  = 3'd3;
  localparam logic [2:0] REG_VAL_LIM   = 3'd4;
  localparam logic [2:0] REG_RSN_LIM   = 3'd5;

  localparam logic [4:0] LEN_VERSION = 5'd7;
  localparam logic [4:0] LEN_CL      = 5'd14;
  localparam logic [4:0] LEN_TE      = 5'd17;
  localparam logic [4:0] LEN_CHUNKED = 5'd7;

  typedef struct packed {
    logic       alpha;
    logic       digit;
    logic       hex_ok;
    logic [3:0] hexv;
    logic       sep;
    logic       tok;
    logic       sp;
    logic       tab;
    logic       cr;
    logic       lf;
    logic       colon;
    logic [7:0] lc;
  } cls_t;

  typedef struct packed {
    logic [7:0] b;
    logic       start;
    cls_t       c;
  } item_t;

  typedef struct packed {
    logic        resp;
    logic [7:0]  mlim;
    logic [15:0] ulim;
    logic [15:0] nlim;
    logic [15:0] vlim;
    logic [15:0] rlim;
  } cfg_t;

  function automatic logic [7:0] lit_ver(input logic [4:0] i);
    case (i)
      5'd0: lit_ver = 8'h48;
      5'd1: lit_ver = 8'h54;
      5'd2: lit_ver = 8'h54;
      5'd3: lit_ver = 8'h50;
      5'd4: lit_ver = 8'h2f;
      5'd5: lit_ver = 8'h31;
      5'd6: lit_ver = 8'h2e;
      default: lit_ver = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] lit_cl(input logic [4:0] i);
    case (i)
      5'd0: lit_cl = "c";  5'd1: lit_cl = "o";  5'd2: lit_cl = "n";  5'd3: lit_cl = "t";
      5'd4: lit_cl = "e";  5'd5: lit_cl = "n";  5'd6: lit_cl = "t";  5'd7: lit_cl = "-";
      5'd8: lit_cl = "l";  5'd9: lit_cl = "e";  5'd10: lit_cl = "n"; 5'd11: lit_cl = "g";
      5'd12: lit_cl = "t"; 5'd13: lit_cl = "h";
      default: lit_cl = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] lit_te(input logic [4:0] i);
    case (i)
      5'd0: lit_te = "t";  5'd1: lit_te = "r";  5'd2: lit_te = "a";  5'd3: lit_te = "n";
      5'd4: lit_te = "s";  5'd5: lit_te = "f";  5'd6: lit_te = "e";  5'd7: lit_te = "r";
      5'd8: lit_te = "-";  5'd9: lit_te = "e";  5'd10: lit_te = "n"; 5'd11: lit_te = "c";
      5'd12: lit_te = "o"; 5'd13: lit_te = "d"; 5'd14: lit_te = "i"; 5'd15: lit_te = "n";
      5'd16: lit_te = "g";
      default: lit_te = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] lit_ch(input logic [4:0] i);
    case (i)
      5'd0: lit_ch = "c"; 5'd1: lit_ch = "h"; 5'd2: lit_ch = "u"; 5'd3: lit_ch = "n";
      5'd4: lit_ch = "k"; 5'd5: lit_ch = "e"; 5'd6: lit_ch = "d";
      default: lit_ch = 8'h00;
    endcase
  endfunction

  function automatic logic [15:0] sat16(input logic [63:0] v);
    sat16 = (v > 64'd65535) ? 16'hffff : v[15:0];
  endfunction

endpackage
`default_nettype wire

@@ hdl/hmp_classify.sv @@
// Front end: accepts input bytes and tags each with its character classes.
`default_nettype none
module hmp_classify import hmp_pkg::*; (
  input  wire  logic [7:0] byte_i,
  input  wire  logic       start_i,
  output item_t            item_o
);
  logic [7:0] b;
  cls_t       c;

  always_comb begin
    b        = byte_i;
    c.alpha  = (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    c.digit  = (b >= "0" && b <= "9");
    c.hex_ok = 1'b1;
    if (c.digit) begin
      c.hexv = b[3:0];
    end else if (b >= "a" && b <= "f") begin
      c.hexv = 4'(b - 8'h57);
    end else if (b >= "A" && b <= "F") begin
      c.hexv = 4'(b - 8'h37);
    end else begin
      c.hexv   = 4'd0;
      c.hex_ok = 1'b0;
    end
    c.sep   = (b <= 8'h20) || (b >= 8'h3a && b <= 8'h40) || b == 8'h22 || b == 8'h28 ||
              b == 8'h29 || (b >= 8'h5b && b <= 8'h5d) || b == 8'h2f || b == 8'h7b ||
              b == 8'h7d;
    c.tok   = (b >= 8'h21 && b <= 8'h7e);
    c.sp    = (b == 8'h20);
    c.tab   = (b == 8'h09);
    c.cr    = (b == 8'h0d);
    c.lf    = (b == 8'h0a);
    c.colon = (b == 8'h3a);
    c.lc    = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    item_o.b     = b;
    item_o.start = start_i;
    item_o.c     = c;
  end
endmodule
`default_nettype wire

@@ hdl/hmp_queue.sv @@
// Short queue of classified items between front end and parser.
`default_nettype none
module hmp_queue import hmp_pkg::*; (
  input  wire  logic  clk_i,
  input  wire  logic  rst_ni,
  input  wire  logic  push_i,
  input  wire  item_t wdata_i,
  output logic        full_o,
  input  wire  logic  pop_i,
  output logic        empty_o,
  output item_t       rdata_o
);
  localparam int unsigned PW = $clog2(QueueDepth);

  item_t         mem_q [QueueDepth];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [PW:0]   cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end
endmodule
`default_nettype wire

@@ hdl/hmp_parse.sv @@
// Back end: message parse state machine with a registered event output.
`default_nettype none
module hmp_parse import hmp_pkg::*; #(
  parameter int unsigned POSITION_BITS = PositionBitsDef,
  parameter int unsigned LENGTH_BITS   = LengthBitsDef
) (
  input  wire  logic         clk_i,
  input  wire  logic         rst_ni,
  input  wire  cfg_t         cfg_i,
  input  wire  logic         empty_i,
  input  wire  item_t        item_i,
  output logic               pop_o,
  output logic               ev_valid_o,
  input  wire  logic         ev_ready_i,
  output logic [2:0]         ev_o,
  output logic [1:0]         kind_o,
  output logic [3:0]         ver_o,
  output logic [15:0]        status_o,
  output logic [15:0]        first_o,
  output logic [15:0]        offset_o,
  output logic [15:0]        length_o,
  output logic               chunked_o,
  output logic [63:0]        body_o
);
  localparam int unsigned PB = POSITION_BITS;
  localparam int unsigned LB = LENGTH_BITS;
  localparam int unsigned XW = 34;

  typedef enum logic [4:0] {
    PH_METH, PH_URI, PH_RVER, PH_RDIG, PH_RCR, PH_RLF,
    PH_SVER, PH_SDIG, PH_SSP, PH_CODE, PH_REASON, PH_RSLF,
    PH_FSTART, PH_FEND_LF, PH_NAME, PH_LWS, PH_VAL, PH_VLF,
    PH_CSIZE, PH_CLF, PH_DONE
  } phase_e;

  phase_e        ph_q, ph_d;
  logic [PB-1:0] lp_q, lp_d, ts_q, ts_d;
  logic [15:0]   nl_q, nl_d, st_q, st_d;
  logic [4:0]    lmi_q, lmi_d;
  logic [2:0]    mf_q, mf_d;
  logic [LB-1:0] vn_q, vn_d, cl_q, cl_d;
  logic [3:0]    ver_q, ver_d;
  logic          chs_q, chs_d, tr_q, tr_d, vad_q, vad_d;

  logic          ov_q;
  logic [2:0]    ev_q, ev_d;
  logic [1:0]    kind_q, kind_d;
  logic [3:0]    over_q, over_d;
  logic [15:0]   ost_q, ost_d, ofirst_q, ofirst_d, ooff_q, ooff_d, olen_q, olen_d;
  logic          och_q, och_d;
  logic [63:0]   obody_q, obody_d;
  logic          emit;

  phase_e        ph;
  logic [PB-1:0] p0, lpn;
  logic          do_name, do_val, bad;
  logic [XW-1:0] vdist, n17, vlen;
  logic [19:0]   stm;
  logic [7:0]    b;
  cls_t          c;

  function automatic logic [XW-1:0] sub0(input logic [XW-1:0] x, input logic [XW-1:0] y);
    sub0 = (x > y) ? x - y : '0;
  endfunction

  assign pop_o = !empty_i && (!ov_q || ev_ready_i);
  assign b     = item_i.b;
  assign c     = item_i.c;

  always_comb begin
    ph    = ph_q;   lp_d  = lp_q;  ts_d  = ts_q;  nl_d  = nl_q;  st_d = st_q;
    lmi_d = lmi_q;  mf_d  = mf_q;  vn_d  = vn_q;  cl_d  = cl_q;  ver_d = ver_q;
    chs_d = chs_q;  tr_d  = tr_q;  vad_d = vad_q;
    if (item_i.start) begin
      ph    = cfg_i.resp ? PH_SVER : PH_METH;
      lp_d  = '0; ts_d = '0; nl_d = '0; lmi_d = '0; mf_d = 3'b111;
      vn_d  = '0; cl_d = '0; st_d = '0; ver_d = '0;
      chs_d = 1'b0; tr_d = 1'b0; vad_d = 1'b1;
    end
    ph_d   = ph;
    p0     = lp_d;
    lpn    = (p0 == '1) ? p0 : p0 + 1'b1;
    lp_d   = lpn;
    emit   = 1'b0;
    ev_d   = EV_ERROR; kind_d = ERR_PROTO; over_d = '0; ost_d = '0;
    ofirst_d = '0; ooff_d = '0; olen_d = '0; och_d = 1'b0; obody_d = '0;
    do_name = 1'b0; do_val = 1'b0; bad = 1'b0;
    vdist  = sub0(XW'(lpn), XW'(nl_d) + XW'(1));
    n17    = XW'(nl_d) + XW'(1);
    vlen   = sub0(XW'(p0), XW'(ts_d) + XW'(1));
    stm    = 20'(st_d) * 20'd10 + 20'(b[3:0]);

    case (ph)
      PH_METH: begin
        if (c.alpha) begin
          if (n17 > XW'(cfg_i.mlim)) begin
            emit = 1'b1; kind_d = ERR_SIZE;
          end else begin
            nl_d = n17[15:0];
          end
        end else if (!c.sp) begin
          emit = 1'b1;
        end else begin
          ts_d = lpn; ph_d = PH_URI;
        end
      end
      PH_URI: begin
        if (c.tok) begin
          if (XW'(lpn) > XW'(cfg_i.ulim)) begin
            emit = 1'b1; kind_d = ERR_SIZE;
          end
        end else if (!c.sp) begin
          emit = 1'b1;
        end else begin
          vn_d  = LB'(sub0(XW'(p0), XW'(ts_d)));
          lmi_d = '0; ph_d = PH_RVER;
        end
      end
      PH_RVER, PH_SVER: begin
        if (lmi_d >= LEN_VERSION || b != lit_ver(lmi_d)) begin
          emit = 1'b1;
        end else begin
          lmi_d = lmi_d + 5'd1;
          if (lmi_d == LEN_VERSION) ph_d = (ph == PH_RVER) ? PH_RDIG : PH_SDIG;
        end
      end
      PH_RDIG, PH_SDIG: begin
        if (!c.digit) begin
          emit = 1'b1;
        end else begin
          ver_d = b[3:0];
          ph_d  = (ph == PH_RDIG) ? PH_RCR : PH_SSP;
        end
      end
      PH_RCR: begin
        if (!c.cr) emit = 1'b1;
        else ph_d = PH_RLF;
      end
      PH_RLF: begin
        emit = 1'b1;
        if (c.lf) begin
          ev_d = EV_REQUEST; over_d = ver_d; ofirst_d = nl_d;
          ooff_d = sat16(64'(ts_d)); olen_d = sat16(64'(vn_d));
          nl_d = '0; lmi_d = '0; mf_d = 3'b111; lp_d = '0; ph_d = PH_FSTART;
        end
      end
      PH_SSP: begin
        if (!c.sp) emit = 1'b1;
        else begin
          st_d = '0; ph_d = PH_CODE;
        end
      end
      PH_CODE: begin
        if (c.sp) begin
          ts_d = lpn; ph_d = PH_REASON;
        end else if (!c.digit) begin
          emit = 1'b1;
        end else begin
          st_d = (stm > 20'd65535) ? 16'hffff : stm[15:0];
        end
      end
      PH_REASON: begin
        if (c.cr) begin
          ph_d = PH_RSLF;
        end else if (sub0(XW'(lpn), XW'(ts_d)) > XW'(cfg_i.rlim)) begin
          emit = 1'b1; kind_d = ERR_SIZE;
        end
      end
      PH_RSLF: begin
        emit = 1'b1;
        if (c.lf) begin
          ev_d = EV_RESPONSE; over_d = ver_d; ost_d = st_d;
          ooff_d = sat16(64'(ts_d)); olen_d = sat16(64'(vlen));
          nl_d = '0; lmi_d = '0; mf_d = 3'b111; lp_d = '0; ph_d = PH_FSTART;
        end
      end
      PH_FSTART: begin
        if (c.cr) ph_d = PH_FEND_LF;
        else begin
          ph_d = PH_NAME; do_name = 1'b1;
        end
      end
      PH_NAME: do_name = 1'b1;
      PH_LWS: begin
        if (c.sp || c.tab) begin
          if (vdist > XW'(cfg_i.vlim)) begin
            emit = 1'b1; kind_d = ERR_SIZE;
          end
        end else begin
          ts_d = p0; ph_d = PH_VAL; do_val = 1'b1;
        end
      end
      PH_VAL: do_val = 1'b1;
      PH_VLF: begin
        emit = 1'b1;
        if (c.lf) begin
          if (!tr_d && cl_d == '0) begin
            if (mf_d[0]) begin
              if (vlen == '0 || !vad_d) bad = 1'b1;
              else cl_d = vn_d;
            end else if (mf_d[1] && mf_d[2] && lmi_d == LEN_CHUNKED) begin
              chs_d = 1'b1;
            end
          end
          if (!bad) begin
            ev_d = EV_FIELD; ofirst_d = nl_d; ooff_d = sat16(64'(ts_d));
            olen_d = sat16(64'(vlen));
            nl_d = '0; lmi_d = '0; mf_d = 3'b111; lp_d = '0; ph_d = PH_FSTART;
          end
        end
      end
      PH_FEND_LF: begin
        emit = 1'b1;
        if (c.lf) begin
          lp_d = '0;
          if (tr_d) begin
            ev_d = EV_TRAILER; ph_d = PH_DONE;
          end else begin
            ev_d = EV_BODY; och_d = chs_d; obody_d = 64'(cl_d);
            vn_d = '0; ph_d = chs_d ? PH_CSIZE : PH_DONE;
          end
        end
      end
      PH_CSIZE: begin
        if (c.hex_ok) vn_d = LB'({vn_d, c.hexv});
        else if (c.cr) ph_d = PH_CLF;
        else emit = 1'b1;
      end
      PH_CLF: begin
        emit = 1'b1;
        if (c.lf) begin
          lp_d = '0;
          if (vn_d == '0) begin
            ev_d = EV_BODY_END; tr_d = 1'b1;
            nl_d = '0; lmi_d = '0; mf_d = 3'b111; ph_d = PH_FSTART;
          end else begin
            ev_d = EV_CHUNK; obody_d = 64'(vn_d); vn_d = '0; ph_d = PH_CSIZE;
          end
        end
      end
      default: begin
        emit = 1'b1; kind_d = ERR_DONE;
      end
    endcase

    if (do_name) begin
      if (c.colon) begin
        if (nl_d != 16'(LEN_CL)) mf_d[0] = 1'b0;
        if (nl_d != 16'(LEN_TE)) mf_d[1] = 1'b0;
        mf_d[2] = 1'b1; lmi_d = '0; vn_d = '0; vad_d = 1'b1; ph_d = PH_LWS;
      end else if (c.sep) begin
        emit = 1'b1;
      end else if (n17 > XW'(cfg_i.nlim)) begin
        emit = 1'b1; kind_d = ERR_SIZE;
      end else begin
        nl_d = n17[15:0];
        if (lmi_d >= LEN_CL || c.lc != lit_cl(lmi_d)) mf_d[0] = 1'b0;
        if (lmi_d >= LEN_TE || c.lc != lit_te(lmi_d)) mf_d[1] = 1'b0;
        if (lmi_d != 5'd31) lmi_d = lmi_d + 5'd1;
      end
    end

    if (do_val) begin
      if (c.cr) begin
        ph_d = PH_VLF;
      end else if (vdist > XW'(cfg_i.vlim)) begin
        emit = 1'b1; kind_d = ERR_SIZE;
      end else begin
        if (c.digit) vn_d = (vn_d << 3) + (vn_d << 1) + LB'(b[3:0]);
        else vad_d = 1'b0;
        if (lmi_d >= LEN_CHUNKED || c.lc != lit_ch(lmi_d)) mf_d[2] = 1'b0;
        if (lmi_d != 5'd31) lmi_d = lmi_d + 5'd1;
      end
    end

    if (emit && ev_d == EV_ERROR) begin
      ph_d = PH_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_METH; lp_q <= '0; ts_q <= '0; nl_q <= '0; st_q <= '0;
      lmi_q <= '0; mf_q <= 3'b111; vn_q <= '0; cl_q <= '0; ver_q <= '0;
      chs_q <= 1'b0; tr_q <= 1'b0; vad_q <= 1'b1; ov_q <= 1'b0;
    end else begin
      if (pop_o) begin
        ph_q <= ph_d; lp_q <= lp_d; ts_q <= ts_d; nl_q <= nl_d; st_q <= st_d;
        lmi_q <= lmi_d; mf_q <= mf_d; vn_q <= vn_d; cl_q <= cl_d; ver_q <= ver_d;
        chs_q <= chs_d; tr_q <= tr_d; vad_q <= vad_d;
      end
      if (pop_o && emit) ov_q <= 1'b1;
      else if (ev_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      ev_q <= ev_d; kind_q <= kind_d; over_q <= over_d; ost_q <= ost_d;
      ofirst_q <= ofirst_d; ooff_q <= ooff_d; olen_q <= olen_d;
      och_q <= och_d; obody_q <= obody_d;
    end
  end

  assign ev_valid_o = ov_q;
  assign ev_o       = ev_q;
  assign kind_o     = kind_q;
  assign ver_o      = over_q;
  assign status_o   = ost_q;
  assign first_o    = ofirst_q;
  assign offset_o   = ooff_q;
  assign length_o   = olen_q;
  assign chunked_o  = och_q;
  assign body_o     = obody_q;
endmodule
`default_nettype wire

@@ hdl/http_message_header_parser.sv @@
// Top level of the HTTP/1.x message header parser: config registers and stream glue.
//
//  channel  | dir | handshake              | payload
//  s_axis   | in  | s_axis_tvalid/tready   | tdata[7:0] byte, tuser[0] start_message
//  m_axis   | out | m_axis_tvalid/tready   | tdata event fields, tuser event/kind
//  cfg      | in  | cfg_valid_i/cfg_ready_o| cfg_index_i register, cfg_data_i value
//
// One byte per cycle sustained while the event output is not stalled; each byte passes
// classify, a 4-item queue and the parse state machine, whose update sets the rate.
// A byte is registered in the queue, and its event in the parser's event output register.
// rst_ni clears the queue, sets the parse state to the request line and resets mode and limits to defaults.
// Output stalls fill the queue; input is refused only when the queue is full.
// The config port is always ready; writes take effect on following bytes.
`default_nettype none
module http_message_header_parser import hmp_pkg::*; #(
  parameter int unsigned POSITION_BITS = PositionBitsDef,
  parameter int unsigned LENGTH_BITS   = LengthBitsDef
) (
  input  wire  logic         clk_i,
  input  wire  logic         rst_ni,
  input  wire  logic         s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  wire  logic         s_axis_tuser,   // [0] start_message
  output logic               m_axis_tvalid,
  input  wire  logic         m_axis_tready,
  // [3:0] version_digit, [19:4] status_code, [35:20] first_length,
  // [51:36] second_offset, [67:52] second_length, [68] chunked_flag,
  // [132:69] body_length, [135:133] zero
  output logic [135:0]       m_axis_tdata,
  output logic [4:0]         m_axis_tuser,   // [2:0] event_res, [4:3] error_kind
  input  wire  logic         cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire  logic [2:0]   cfg_index_i,
  input  wire  logic [15:0]  cfg_data_i
);
  cfg_t  cfg_q;
  item_t in_item, q_item;
  logic  q_full, q_empty, q_pop;
  logic  push;

  logic [2:0]  ev;
  logic [1:0]  kind;
  logic [3:0]  ver;
  logic [15:0] status, first, offset, length;
  logic        chunked;
  logic [63:0] body;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  // limit and mode registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.resp <= 1'b0;
      cfg_q.mlim <= 8'd32;
      cfg_q.ulim <= 16'd8192;
      cfg_q.nlim <= 16'd256;
      cfg_q.vlim <= 16'd8192;
      cfg_q.rlim <= 16'd256;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_RESP_MODE: cfg_q.resp <= cfg_data_i[0];
        REG_METH_LIM:  cfg_q.mlim <= cfg_data_i[7:0];
        REG_URI_LIM:   cfg_q.ulim <= cfg_data_i;
        REG_NAME_LIM:  cfg_q.nlim <= cfg_data_i;
        REG_VAL_LIM:   cfg_q.vlim <= cfg_data_i;
        REG_RSN_LIM:   cfg_q.rlim <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hmp_classify u_classify (
    .byte_i  (s_axis_tdata),
    .start_i (s_axis_tuser),
    .item_o  (in_item)
  );

  hmp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (in_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_item)
  );

  hmp_parse #(
    .POSITION_BITS (POSITION_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .empty_i    (q_empty),
    .item_i     (q_item),
    .pop_o      (q_pop),
    .ev_valid_o (m_axis_tvalid),
    .ev_ready_i (m_axis_tready),
    .ev_o       (ev),
    .kind_o     (kind),
    .ver_o      (ver),
    .status_o   (status),
    .first_o    (first),
    .offset_o   (offset),
    .length_o   (length),
    .chunked_o  (chunked),
    .body_o     (body)
  );

  assign m_axis_tdata = {3'b000, body, chunked, length, offset, first, status, ver};
  assign m_axis_tuser = {kind, ev};
endmodule
`default_nettype wire
